// ----- hw/rtl/energy_gated_angular_correlator_defines.svh -----
// ----------------------------------------------------------------------------
// Energy gated angular correlator: assertion macros
// Shared property wrappers clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ENERGY_GATED_ANGULAR_CORRELATOR_DEFINES_SVH
`define ENERGY_GATED_ANGULAR_CORRELATOR_DEFINES_SVH

// checked outside reset
`define EGAC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define EGAC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/egac_pkg.sv -----
// ----------------------------------------------------------------------------
// Energy gated angular correlator package
// Widths, register indexes, controller codes and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package egac_pkg;

  localparam int CoordBits   = 32;
  localparam int CosFracBits = 15;
  localparam int QBits       = CosFracBits + 2;
  localparam int CosW        = 16;
  localparam int EnergyW     = 24;
  localparam int IndexW      = 4;
  localparam int NumWin      = 4;
  localparam int NumRegs     = 2 * NumWin;
  localparam int MulW        = CoordBits + 1;
  localparam int ProdW       = 2 * MulW;
  localparam int NormW       = 2 * CoordBits;
  localparam int DotW        = ProdW;
  localparam int PW          = 2 * NormW;
  localparam int RootW       = NormW;
  localparam int RemW        = RootW + 4;
  localparam int NumW        = NormW + QBits - 1;
  localparam int CntW        = 6;

  localparam logic [QBits-1:0] QOne = QBits'(1) << CosFracBits;

  // window slots, also flag bits
  localparam int WinG1 = 0;
  localparam int WinG2 = 1;
  localparam int WinE1 = 2;
  localparam int WinE2 = 3;

  localparam logic [1:0] KindG1G2 = 2'd0;
  localparam logic [1:0] KindG1E2 = 2'd1;
  localparam logic [1:0] KindE1G2 = 2'd2;
  localparam logic [1:0] KindE1E2 = 2'd3;

  localparam logic [EnergyW-1:0] WinLoReset [NumWin] =
    '{24'd635000, 24'd410000, 24'd552000, 24'd327000};
  localparam logic [EnergyW-1:0] WinHiReset [NumWin] =
    '{24'd637000, 24'd413000, 24'd554000, 24'd330000};

  // multiplier schedule
  localparam logic [3:0] MulSqA    = 4'd0;
  localparam logic [3:0] MulSqB    = 4'd3;
  localparam logic [3:0] MulCross  = 4'd6;
  localparam logic [3:0] MulNormLL = 4'd9;
  localparam logic [3:0] MulNormLH = 4'd10;
  localparam logic [3:0] MulNormHL = 4'd11;
  localparam logic [3:0] MulNormHH = 4'd12;
  localparam logic [3:0] MulSteps  = 4'd13;

  localparam logic [CntW-1:0] SqrtLast = CntW'(RootW - 1);
  localparam logic [CntW-1:0] DivLast  = CntW'(QBits - 1);

  typedef struct packed {
    logic       check;
    logic       mul_en;
    logic [3:0] mul_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } egac_cmd_t;

  typedef struct packed {
    logic pair_hit;
    logic zero_norm;
    logic out_free;
  } egac_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/egac_hit_if.sv -----
// ----------------------------------------------------------------------------
// Hit request channel
// Valid/ready channel carrying one detector hit.
// ----------------------------------------------------------------------------
`default_nettype none

interface egac_hit_if;
  logic               valid;
  logic               ready;
  logic [23:0]        hit_energy;
  logic               in_outer_volume;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, hit_energy, in_outer_volume, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, hit_energy, in_outer_volume, pos_x, pos_y, pos_z,
                output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/egac_pair_if.sv -----
// ----------------------------------------------------------------------------
// Pair result channel
// Valid/ready channel carrying one correlation result.
// ----------------------------------------------------------------------------
`default_nettype none

interface egac_pair_if;
  logic               valid;
  logic               ready;
  logic [1:0]         pair_kind;
  logic signed [15:0] cosine;
  logic               zero_norm;

  modport source (output valid, pair_kind, cosine, zero_norm, input ready);
  modport sink (input valid, pair_kind, cosine, zero_norm, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/egac_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready register write: index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface egac_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/energy_gated_angular_correlator.sv -----
// ----------------------------------------------------------------------------
// Energy gated angular correlator
// Classifies hits by energy window and reports pair angle cosines.
// ----------------------------------------------------------------------------
// Usage:
//   hit  : one request per detector hit (energy, outer flag, exit position).
//   pair : one request per completed pair (kind, Q1.15 cosine, zero flag).
//   cfg  : window bound writes, always ready; write only while idle.
// Timing:
//   A hit that completes no pair returns to idle after the check state. A pair
//   with a zero-length vector goes from the multiplies to the result register;
//   a normal pair makes 13 passes through the shared 33x33 multiplier, then
//   runs the 64-step square root and the 17-step divide.
//   One hit is processed at a time; hit.ready is high only when idle.
// Reset:
//   Windows return to their default bounds, found flags clear, no result.
// Stall:
//   A result waits in the output register; the next hit is accepted
//   meanwhile, and a new result waits until the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "energy_gated_angular_correlator_defines.svh"

module energy_gated_angular_correlator import egac_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  egac_hit_if.sink    hit,
  egac_pair_if.source pair,
  egac_cfg_if.sink    cfg
);

  egac_cmd_t    cmd;
  egac_status_t status;
  logic         hit_ready;
  logic         hit_fire;
  logic         cfg_fire;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign hit.ready = hit_ready;
  assign hit_fire  = hit.valid && hit_ready;

  egac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .hit_fire  (hit_fire),
    .status    (status),
    .hit_ready (hit_ready),
    .cmd       (cmd)
  );

  egac_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_fire        (cfg_fire),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .hit_fire        (hit_fire),
    .hit_energy      (hit.hit_energy),
    .in_outer_volume (hit.in_outer_volume),
    .pos_x           (hit.pos_x),
    .pos_y           (hit.pos_y),
    .pos_z           (hit.pos_z),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (pair.ready),
    .out_valid       (pair.valid),
    .out_kind        (pair.pair_kind),
    .out_cosine      (pair.cosine),
    .out_zero        (pair.zero_norm)
  );

  `EGAC_ASSERT_ALWAYS(a_no_result_after_reset, $past(rst) |-> !pair.valid, "result after reset")
  `EGAC_ASSERT(a_busy_after_accept, hit.valid && hit.ready |=> !hit.ready, "ready after accept")
  `EGAC_ASSERT(a_result_while_busy, $rose(pair.valid) |-> $past(!hit.ready), "result while idle")

endmodule

`default_nettype wire

// ----- hw/rtl/egac_ctrl.sv -----
// ----------------------------------------------------------------------------
// Correlator controller
// Sequences classification, multiplies, square root, divide and output.
// ----------------------------------------------------------------------------
`default_nettype none

module egac_ctrl import egac_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         hit_fire,
  input  wire egac_status_t status,
  output logic              hit_ready,
  output egac_cmd_t         cmd
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StEval  = 3'd3;
  localparam logic [2:0] StSqrt  = 3'd4;
  localparam logic [2:0] StDivI  = 3'd5;
  localparam logic [2:0] StDiv   = 3'd6;
  localparam logic [2:0] StFin   = 3'd7;

  logic [2:0]      state, state_next;
  logic [CntW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    hit_ready  = 1'b0;
    case (state)
      StIdle: begin
        hit_ready = 1'b1;
        if (hit_fire) state_next = StCheck;
      end
      StCheck: begin
        cmd.check = 1'b1;
        cnt_next  = '0;
        state_next = status.pair_hit ? StMul : StIdle;
      end
      StMul: begin
        cmd.mul_step = cnt[3:0];
        cmd.mul_en   = (cnt[3:0] != MulSteps);
        cnt_next     = cnt + 1'b1;
        if (cnt[3:0] == MulSteps) state_next = StEval;
      end
      StEval: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = '0;
        state_next    = status.zero_norm ? StFin : StSqrt;
      end
      StSqrt: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == SqrtLast) state_next = StDivI;
      end
      StDivI: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = StDiv;
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DivLast) state_next = StFin;
      end
      StFin: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/egac_datapath.sv -----
// ----------------------------------------------------------------------------
// Correlator datapath
// Windows, vectors, flags, shared multiplier, root and divide units, output.
// ----------------------------------------------------------------------------
`default_nettype none

module egac_datapath import egac_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_fire,
  input  wire logic [IndexW-1:0]      cfg_index,
  input  wire logic [EnergyW-1:0]     cfg_data,
  input  wire logic                   hit_fire,
  input  wire logic [EnergyW-1:0]     hit_energy,
  input  wire logic                   in_outer_volume,
  input  wire logic signed [31:0]     pos_x,
  input  wire logic signed [31:0]     pos_y,
  input  wire logic signed [31:0]     pos_z,
  input  wire egac_cmd_t              cmd,
  output egac_status_t                status,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [1:0]                  out_kind,
  output logic signed [CosW-1:0]      out_cosine,
  output logic                        out_zero
);

  logic [EnergyW-1:0]          win_lo [NumWin];
  logic [EnergyW-1:0]          win_hi [NumWin];
  logic signed [CoordBits-1:0] vec [NumWin][3];
  logic [NumWin-1:0]           flags;
  logic [NumWin-1:0]           match;
  logic [1:0]                  kind, pair_kind;
  logic                        pair_hit;

  logic signed [CoordBits-1:0] av [3];
  logic signed [CoordBits-1:0] bv [3];
  logic signed [MulW-1:0]      mul_a, mul_b;
  logic signed [ProdW-1:0]     prod;
  logic [3:0]                  prod_step;
  logic                        prod_vld;
  logic [1:0]                  mi, ai;
  logic [NormW-1:0]            na, nb;
  logic signed [DotW-1:0]      dot;
  logic [PW-1:0]               p;

  logic [PW-1:0]               rad;
  logic [RemW-1:0]             rem, rem_sh, trial;
  logic [RootW-1:0]            root;
  logic [NumW-1:0]             num, ds;
  logic [QBits-1:0]            q, qs;
  logic                        neg;
  logic [NormW-1:0]            mag;
  logic [CosW-1:0]             cos_val;

  // window match and pair selection
  always_comb begin
    for (int k = 0; k < NumWin; k++) begin
      match[k] = in_outer_volume && (hit_energy > win_lo[k]) && (hit_energy < win_hi[k]);
    end
    pair_hit  = 1'b1;
    pair_kind = KindG1G2;
    if (flags[WinG1] && flags[WinG2])      pair_kind = KindG1G2;
    else if (flags[WinG1] && flags[WinE2]) pair_kind = KindG1E2;
    else if (flags[WinE1] && flags[WinG2]) pair_kind = KindE1G2;
    else if (flags[WinE1] && flags[WinE2]) pair_kind = KindE1E2;
    else pair_hit = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumWin; k++) begin
        win_lo[k] <= WinLoReset[k];
        win_hi[k] <= WinHiReset[k];
      end
    end else if (cfg_fire && (cfg_index < IndexW'(NumRegs))) begin
      if (cfg_index[0]) win_hi[cfg_index[2:1]] <= cfg_data;
      else              win_lo[cfg_index[2:1]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (hit_fire) begin
      if (match[WinG1])      flags <= (flags | 4'b0001) & 4'b1001;
      else if (match[WinG2]) flags <= (flags | 4'b0010) & 4'b0111;
      else if (match[WinE1]) flags <= 4'b0100;
      else if (match[WinE2]) flags <= (flags | 4'b1000) & 4'b1100;
    end else if (cmd.check && pair_hit) begin
      flags <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_fire) begin
      for (int k = 0; k < NumWin; k++) begin
        if (match[k] && (match & ((NumWin'(1) << k) - 1'b1)) == '0) begin
          vec[k][0] <= pos_x[CoordBits-1:0];
          vec[k][1] <= pos_y[CoordBits-1:0];
          vec[k][2] <= pos_z[CoordBits-1:0];
        end
      end
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      kind <= pair_kind;
      for (int i = 0; i < 3; i++) begin
        av[i] <= pair_kind[1] ? vec[WinE1][i] : vec[WinG1][i];
        bv[i] <= pair_kind[0] ? vec[WinE2][i] : vec[WinG2][i];
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mi    = '0;
    if (cmd.mul_step < MulSqB) begin
      mi    = 2'(cmd.mul_step - MulSqA);
      mul_a = {av[mi][CoordBits-1], av[mi]};
      mul_b = {av[mi][CoordBits-1], av[mi]};
    end else if (cmd.mul_step < MulCross) begin
      mi    = 2'(cmd.mul_step - MulSqB);
      mul_a = {bv[mi][CoordBits-1], bv[mi]};
      mul_b = {bv[mi][CoordBits-1], bv[mi]};
    end else if (cmd.mul_step < MulNormLL) begin
      mi    = 2'(cmd.mul_step - MulCross);
      mul_a = {av[mi][CoordBits-1], av[mi]};
      mul_b = {bv[mi][CoordBits-1], bv[mi]};
    end else begin
      case (cmd.mul_step)
        MulNormLL: begin
          mul_a = {1'b0, na[NormW/2-1:0]};
          mul_b = {1'b0, nb[NormW/2-1:0]};
        end
        MulNormLH: begin
          mul_a = {1'b0, na[NormW/2-1:0]};
          mul_b = {1'b0, nb[NormW-1:NormW/2]};
        end
        MulNormHL: begin
          mul_a = {1'b0, na[NormW-1:NormW/2]};
          mul_b = {1'b0, nb[NormW/2-1:0]};
        end
        MulNormHH: begin
          mul_a = {1'b0, na[NormW-1:NormW/2]};
          mul_b = {1'b0, nb[NormW-1:NormW/2]};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= mul_a * mul_b;
    prod_step <= cmd.mul_step;
  end

  // accumulate the registered product in the cycle after the multiply
  always_comb begin
    ai = '0;
    if (prod_step < MulSqB) ai = 2'(prod_step - MulSqA);
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      na  <= '0;
      nb  <= '0;
      dot <= '0;
      p   <= '0;
    end else if (prod_vld) begin
      if (prod_step < MulSqB) begin
        na <= na + prod[NormW-1:0] + NormW'(ai & 2'b00);
      end else if (prod_step < MulCross) begin
        nb <= nb + prod[NormW-1:0];
      end else if (prod_step < MulNormLL) begin
        dot <= dot + prod;
      end else begin
        case (prod_step)
          MulNormLL: p <= p + {{NormW{1'b0}}, prod[NormW-1:0]};
          MulNormLH,
          MulNormHL: p <= p + ({{NormW{1'b0}}, prod[NormW-1:0]} << (NormW / 2));
          MulNormHH: p <= p + ({{NormW{1'b0}}, prod[NormW-1:0]} << NormW);
          default:   p <= p;
        endcase
      end
    end
  end

  // bit-pair square root, one result bit per step
  always_comb begin
    rem_sh = {rem[RemW-3:0], rad[PW-1:PW-2]};
    trial  = {2'b00, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rad  <= p;
      rem  <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RootW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RootW-2:0], 1'b0};
      end
    end
  end

  // restoring divide, one quotient bit per step
  always_comb begin
    neg = dot[DotW-1];
    mag = neg ? (NormW'(0) - dot[NormW-1:0]) : dot[NormW-1:0];
    if (neg) qs = (q > QOne) ? QOne : q;
    else     qs = (q > (QOne - 1'b1)) ? (QOne - 1'b1) : q;
    cos_val = neg ? CosW'(QBits'(~qs + QBits'(1))) : CosW'(qs);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num <= {1'b0, mag, {CosFracBits{1'b0}}};
      ds  <= {root, {(QBits-1){1'b0}}};
      q   <= '0;
    end else if (cmd.div_step) begin
      ds <= ds >> 1;
      if (num >= ds) begin
        num <= num - ds;
        q   <= {q[QBits-2:0], 1'b1};
      end else begin
        q   <= {q[QBits-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind   <= kind;
      out_zero   <= status.zero_norm;
      out_cosine <= status.zero_norm ? '0 : cos_val;
    end
  end

  always_comb begin
    status.pair_hit  = pair_hit;
    status.zero_norm = (na == '0) || (nb == '0);
    status.out_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire
